### rtl/fpes_pkg.sv
package fpes_pkg;

  // command codes carried in the low bits of s_axis_tuser
  localparam logic [2:0] OP_ERASE_CHIP = 3'd0;
  localparam logic [2:0] OP_ERASE_PAGE = 3'd1;
  localparam logic [2:0] OP_PROG_OPEN  = 3'd2;
  localparam logic [2:0] OP_PROG_WORD  = 3'd3;
  localparam logic [2:0] OP_PROG_CLOSE = 3'd4;
  localparam logic [2:0] OP_READ       = 3'd5;
  localparam logic [2:0] OP_END        = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_CODE_BASE = 2'd0;
  localparam logic [1:0] REG_DATA_BASE = 2'd1;
  localparam logic [1:0] REG_DELAY     = 2'd2;

  // control bit layout
  localparam logic [13:0] C_CON   = 14'h0001;
  localparam logic [13:0] C_DELAY = 14'h0038;
  localparam logic [13:0] C_XE    = 14'h0040;
  localparam logic [13:0] C_YE    = 14'h0080;
  localparam logic [13:0] C_SE    = 14'h0100;
  localparam logic [13:0] C_IFREN = 14'h0200;
  localparam logic [13:0] C_ERASE = 14'h0400;
  localparam logic [13:0] C_MAS1  = 14'h0800;
  localparam logic [13:0] C_PROG  = 14'h1000;
  localparam logic [13:0] C_NVSTR = 14'h2000;

  localparam logic [13:0] C_ERASE_CLR = C_XE | C_YE | C_SE | C_MAS1 | C_ERASE | C_NVSTR;
  localparam logic [13:0] C_NOT_DELAY = ~C_DELAY;

  localparam int unsigned UpcW = 5;

  // microcode entry points
  localparam logic [UpcW-1:0] UA_ERASE_CHIP = 5'd0;
  localparam logic [UpcW-1:0] UA_ERASE_PAGE = 5'd4;
  localparam logic [UpcW-1:0] UA_PROG_OPEN  = 5'd8;
  localparam logic [UpcW-1:0] UA_PROG_WORD  = 5'd10;
  localparam logic [UpcW-1:0] UA_PROG_CLOSE = 5'd12;
  localparam logic [UpcW-1:0] UA_READ       = 5'd14;
  localparam logic [UpcW-1:0] UA_END        = 5'd16;

  typedef enum logic [1:0] {
    ADDR_ZERO,
    ADDR_BASE,
    ADDR_CLAMP,
    ADDR_ALIGN
  } addr_sel_e;

  typedef enum logic [2:0] {
    HOLD_0,
    HOLD_1,
    HOLD_2,
    HOLD_6,
    HOLD_11,
    HOLD_50,
    HOLD_110,
    HOLD_50000
  } hold_sel_e;

  typedef struct packed {
    logic [13:0]     set;
    logic [13:0]     clr;
    addr_sel_e       addr_sel;
    logic            add_sec;   // add sector offset to the address
    logic            data_en;
    hold_sel_e       hold_sel;
    logic            sample;
    logic            jmp;       // jump back while sectors remain
    logic [UpcW-1:0] tgt;
    logic            done;
    logic            idle;      // image drops to delay bits after the last step
  } ucode_t;

  function automatic logic [15:0] hold_value(hold_sel_e sel);
    logic [15:0] v;
    unique case (sel)
      HOLD_0:     v = 16'd0;
      HOLD_1:     v = 16'd1;
      HOLD_2:     v = 16'd2;
      HOLD_6:     v = 16'd6;
      HOLD_11:    v = 16'd11;
      HOLD_50:    v = 16'd50;
      HOLD_110:   v = 16'd110;
      HOLD_50000: v = 16'd50000;
      default:    v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic ucode_t ucode_rom(logic [UpcW-1:0] upc);
    ucode_t uw;
    uw = '0;
    unique case (upc)
      // erase chip, one sector per pass
      5'd0: uw = '{C_XE | C_ERASE | C_MAS1, C_ERASE_CLR, ADDR_BASE, 1'b1, 1'b0, HOLD_6,
                   1'b0, 1'b0, 5'd0, 1'b0, 1'b0};
      5'd1: uw = '{C_NVSTR, 14'h0, ADDR_BASE, 1'b1, 1'b0, HOLD_50000,
                   1'b0, 1'b0, 5'd0, 1'b0, 1'b0};
      5'd2: uw = '{14'h0, C_ERASE, ADDR_BASE, 1'b1, 1'b0, HOLD_110,
                   1'b0, 1'b0, 5'd0, 1'b0, 1'b0};
      5'd3: uw = '{14'h0, C_XE | C_MAS1 | C_NVSTR, ADDR_BASE, 1'b1, 1'b0, HOLD_2,
                   1'b0, 1'b1, UA_ERASE_CHIP, 1'b1, 1'b1};
      // erase page
      5'd4: uw = '{C_XE | C_ERASE, C_ERASE_CLR, ADDR_CLAMP, 1'b1, 1'b0, HOLD_6,
                   1'b0, 1'b0, 5'd0, 1'b0, 1'b0};
      5'd5: uw = '{C_NVSTR, 14'h0, ADDR_CLAMP, 1'b1, 1'b0, HOLD_50000,
                   1'b0, 1'b0, 5'd0, 1'b0, 1'b0};
      5'd6: uw = '{14'h0, C_ERASE, ADDR_CLAMP, 1'b1, 1'b0, HOLD_6,
                   1'b0, 1'b0, 5'd0, 1'b0, 1'b0};
      5'd7: uw = '{14'h0, C_XE | C_NVSTR, ADDR_CLAMP, 1'b1, 1'b0, HOLD_2,
                   1'b0, 1'b1, UA_ERASE_PAGE, 1'b1, 1'b1};
      // program open
      5'd8: uw = '{C_XE | C_PROG, 14'h0, ADDR_ALIGN, 1'b0, 1'b0, HOLD_6,
                   1'b0, 1'b0, 5'd0, 1'b0, 1'b0};
      5'd9: uw = '{C_NVSTR, 14'h0, ADDR_ALIGN, 1'b0, 1'b0, HOLD_11,
                   1'b0, 1'b0, 5'd0, 1'b1, 1'b0};
      // program word
      5'd10: uw = '{C_YE, 14'h0, ADDR_ALIGN, 1'b0, 1'b1, HOLD_50,
                    1'b0, 1'b0, 5'd0, 1'b0, 1'b0};
      5'd11: uw = '{14'h0, C_YE, ADDR_ALIGN, 1'b0, 1'b1, HOLD_1,
                    1'b0, 1'b0, 5'd0, 1'b1, 1'b0};
      // program close
      5'd12: uw = '{14'h0, C_PROG, ADDR_ZERO, 1'b0, 1'b0, HOLD_6,
                    1'b0, 1'b0, 5'd0, 1'b0, 1'b0};
      5'd13: uw = '{14'h0, C_XE | C_NVSTR, ADDR_ZERO, 1'b0, 1'b0, HOLD_1,
                    1'b0, 1'b0, 5'd0, 1'b1, 1'b0};
      // read word
      5'd14: uw = '{C_XE | C_YE | C_SE, 14'h0, ADDR_ALIGN, 1'b0, 1'b0, HOLD_1,
                    1'b1, 1'b0, 5'd0, 1'b0, 1'b0};
      5'd15: uw = '{14'h0, C_XE | C_YE | C_SE, ADDR_ALIGN, 1'b0, 1'b0, HOLD_1,
                    1'b0, 1'b0, 5'd0, 1'b1, 1'b1};
      // session end
      5'd16: uw = '{14'h0, C_NOT_DELAY, ADDR_ZERO, 1'b0, 1'b0, HOLD_0,
                    1'b0, 1'b0, 5'd0, 1'b1, 1'b0};
      default: uw = '0;
    endcase
    return uw;
  endfunction

endpackage

### rtl/flash_program_erase_sequencer_unit.sv
// each command yields 0 to 16 steps, the first registered once the output register can take it
// erase commands yield 16 steps (four sectors of four steps), the others at most 2
// the next command can be taken once its predecessor's last step is registered
// output back-pressure stalls the step counter; a command that emits nothing leaves the unit ready
// asynchronous active-low reset clears the command image, region bases and delay to zero
module flash_program_erase_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // address[31:0], word_data[63:32], valid_bytes[66:64]
  input  logic [3:0]  s_axis_tuser_i,   // op[2:0], region[3]

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,   // control[13:0], flash_address[45:14],
                                        // write_word[77:46], hold_us[93:78]
  output logic        m_axis_tuser_o,   // sample_read
  output logic        m_axis_tlast_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] code_base_q, code_base_d;
  logic [31:0] data_base_q, data_base_d;
  logic [2:0]  delay_q, delay_d;
  logic [13:0] image_q, image_d;
  logic        busy_q, busy_d;
  logic [fpes_pkg::UpcW-1:0] upc_q, upc_d;
  logic [1:0]  sec_q, sec_d;
  logic [31:0] base_q, base_d;
  logic [31:0] clamp_q, clamp_d;
  logic [31:0] word_q, word_d;

  logic        m_valid_q, m_valid_d;
  logic [95:0] m_data_q, m_data_d;
  logic        m_user_q, m_user_d;
  logic        m_last_q, m_last_d;

  fpes_pkg::ucode_t uw;
  logic        step_fire, in_fire, loop_back, step_last;
  logic [13:0] image_step, session_img;
  logic [31:0] addr_sel, step_addr, step_word;
  logic [2:0]  in_op;
  logic        in_region;
  logic [31:0] in_addr, in_data, in_base, in_word;
  logic [2:0]  in_vb;
  logic        in_start;
  logic [fpes_pkg::UpcW-1:0] in_entry;

  assign s_axis_tready_o = !busy_q;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  assign in_op     = s_axis_tuser_i[2:0];
  assign in_region = s_axis_tuser_i[3];
  assign in_addr   = s_axis_tdata_i[31:0];
  assign in_data   = s_axis_tdata_i[63:32];
  assign in_vb     = s_axis_tdata_i[66:64];
  assign in_base   = in_region ? data_base_q : code_base_q;
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;

  assign session_img = ({11'd0, delay_q} << 3) | fpes_pkg::C_CON
                     | (in_region ? fpes_pkg::C_IFREN : 14'h0);

  // upper unused bytes of a partial tail word read as erased
  always_comb begin
    case (in_vb)
      3'd1:    in_word = {24'hFFFFFF, in_data[7:0]};
      3'd2:    in_word = {16'hFFFF, in_data[15:0]};
      3'd3:    in_word = {8'hFF, in_data[23:0]};
      default: in_word = in_data;
    endcase
  end

  always_comb begin
    in_start = 1'b1;
    in_entry = fpes_pkg::UA_END;
    unique case (in_op)
      fpes_pkg::OP_ERASE_CHIP: in_entry = fpes_pkg::UA_ERASE_CHIP;
      fpes_pkg::OP_ERASE_PAGE: in_entry = fpes_pkg::UA_ERASE_PAGE;
      fpes_pkg::OP_PROG_OPEN:  in_entry = fpes_pkg::UA_PROG_OPEN;
      fpes_pkg::OP_PROG_WORD: begin
        in_entry = fpes_pkg::UA_PROG_WORD;
        in_start = (in_vb != 3'd0);
      end
      fpes_pkg::OP_PROG_CLOSE: in_entry = fpes_pkg::UA_PROG_CLOSE;
      fpes_pkg::OP_READ:       in_entry = fpes_pkg::UA_READ;
      fpes_pkg::OP_END:        in_entry = fpes_pkg::UA_END;
      default:                 in_start = 1'b0;
    endcase
  end

  assign uw         = fpes_pkg::ucode_rom(upc_q);
  assign step_fire  = busy_q && (!m_valid_q || m_axis_tready_i);
  assign image_step = (image_q & ~uw.clr) | uw.set;
  assign loop_back  = uw.jmp && (sec_q != 2'd3);
  assign step_last  = uw.done && !loop_back;

  always_comb begin
    unique case (uw.addr_sel)
      fpes_pkg::ADDR_ZERO:  addr_sel = 32'd0;
      fpes_pkg::ADDR_BASE:  addr_sel = base_q;
      fpes_pkg::ADDR_CLAMP: addr_sel = clamp_q;
      fpes_pkg::ADDR_ALIGN: addr_sel = {clamp_q[31:2], 2'b00};
      default:              addr_sel = 32'd0;
    endcase
  end

  assign step_addr = addr_sel + (uw.add_sec ? {28'd0, sec_q, 2'b00} : 32'd0);
  assign step_word = uw.data_en ? word_q : 32'd0;

  always_comb begin
    code_base_d = code_base_q;
    data_base_d = data_base_q;
    delay_d     = delay_q;
    image_d     = image_q;
    busy_d      = busy_q;
    upc_d       = upc_q;
    sec_d       = sec_q;
    base_d      = base_q;
    clamp_d     = clamp_q;
    word_d      = word_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    m_user_d    = m_user_q;
    m_last_d    = m_last_q;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fpes_pkg::REG_CODE_BASE: code_base_d = cfg_data_i;
        fpes_pkg::REG_DATA_BASE: data_base_d = cfg_data_i;
        fpes_pkg::REG_DELAY:     delay_d     = cfg_data_i[2:0];
        default: ;
      endcase
    end

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    if (step_fire) begin
      m_valid_d = 1'b1;
      m_data_d  = {2'b00, fpes_pkg::hold_value(uw.hold_sel), step_word, step_addr, image_step};
      m_user_d  = uw.sample;
      m_last_d  = step_last;
      image_d   = (uw.idle && step_last) ? (image_step & fpes_pkg::C_DELAY) : image_step;
      if (loop_back) begin
        upc_d = uw.tgt;
        sec_d = sec_q + 2'd1;
      end else if (step_last) begin
        busy_d = 1'b0;
      end else begin
        upc_d = upc_q + 1'b1;
      end
    end

    if (in_fire) begin
      busy_d  = in_start;
      upc_d   = in_entry;
      sec_d   = 2'd0;
      base_d  = in_base;
      clamp_d = (in_addr < in_base) ? in_base : in_addr;
      word_d  = in_word;
      if (in_op == fpes_pkg::OP_ERASE_CHIP || in_op == fpes_pkg::OP_ERASE_PAGE ||
          in_op == fpes_pkg::OP_PROG_OPEN || in_op == fpes_pkg::OP_READ) begin
        image_d = session_img;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_base_q <= '0;
      data_base_q <= '0;
      delay_q     <= '0;
      image_q     <= '0;
      busy_q      <= 1'b0;
      upc_q       <= '0;
      sec_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      code_base_q <= code_base_d;
      data_base_q <= data_base_d;
      delay_q     <= delay_d;
      image_q     <= image_d;
      busy_q      <= busy_d;
      upc_q       <= upc_d;
      sec_q       <= sec_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // command operands and output payload
  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    clamp_q  <= clamp_d;
    word_q   <= word_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

endmodule
